// ----- rtl/core/btr_pkg.sv -----
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types and constants of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

  // Field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FONT_ADDR_W = 12;
  localparam int unsigned STRIDE_W    = 5;
  localparam int unsigned CMD_IDX_W   = 13;  // holds 255 * 31 and any load address
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Glyph geometry
  localparam int unsigned GLYPH_ROWS     = 16;
  localparam int unsigned ROW_W          = 4;
  localparam int unsigned CHAR_ADVANCE   = 8;
  localparam int unsigned LINE_ADVANCE   = 16;
  localparam int unsigned CURSOR_X_RESET = 50;
  localparam int unsigned CURSOR_Y_RESET = 120;

  // Sizes
  localparam int unsigned GLYPH_STORE_DEPTH_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH           = 2;
  localparam int unsigned QUEUE_PTR_W           = 1;
  localparam int unsigned QUEUE_CNT_W           = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;

  // Register reset values
  localparam logic [ADDR_W-1:0]   BASE_RESET   = 32'h0000_0000;
  localparam logic [COORD_W-1:0]  PITCH_RESET  = 16'd1024;
  localparam logic [COORD_W-1:0]  WIDTH_RESET  = 16'd1024;
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'hFF00_00FF;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd16;

  // Input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [COORD_W-1:0]  pitch;
    logic [COORD_W-1:0]  width;
    logic [COLOR_W-1:0]  color;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_DRAW
  } cmd_kind_t;

  // One queued command: a store write, or a glyph draw at a fixed cursor
  typedef struct packed {
    cmd_kind_t            kind;
    logic [CMD_IDX_W-1:0] index;      // load address, or code * stride
    logic [BYTE_W-1:0]    font_byte;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
  } cmd_t;

endpackage

// ----- rtl/core/btr_if.sv -----
// ----------------------------------------------------------------------------
// btr_in_if / btr_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface btr_in_if import btr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [FONT_ADDR_W-1:0] font_address;
  logic [BYTE_W-1:0]      font_byte;
  logic [CODE_W-1:0]      char_code;

  modport source (output valid, func, font_address, font_byte, char_code, input ready);
  modport sink   (input valid, func, font_address, font_byte, char_code, output ready);
endinterface

interface btr_out_if import btr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [BYTE_W-1:0]  row_mask;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_row;

  modport source (output valid, pixel_address, row_mask, pixel_color, last_row,
                  input ready);
  modport sink   (input valid, pixel_address, row_mask, pixel_color, last_row,
                  output ready);
endinterface

// ----- rtl/core/bitmap_font_text_renderer_core.sv -----
// Draw item: it passes the queue slot, the back's capture, the index reduction and
//   the read stage to the output register; then one row per cycle unless the
//   output stalls. The glyph index is reduced by subtracting the store depth.
// Load item: the back reduces the index, then writes the store once it is below the depth.
// Reset clears control state, sets the cursor to (50, 120) and the registers to
//   their defaults; the glyph store is not cleared.
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_core
// Renders 8x16 bitmap font characters as masked framebuffer row writes.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_core import btr_pkg::*; #(
  parameter int unsigned GLYPH_STORE_DEPTH = GLYPH_STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  btr_in_if.sink                in_ch,
  btr_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(GLYPH_STORE_DEPTH);

  cfg_t              cfg_r;
  logic              q_full;
  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_head;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base   <= BASE_RESET;
      cfg_r.pitch  <= PITCH_RESET;
      cfg_r.width  <= WIDTH_RESET;
      cfg_r.color  <= COLOR_RESET;
      cfg_r.stride <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:   cfg_r.base   <= cfg_wdata[ADDR_W-1:0];
        REG_PITCH:  cfg_r.pitch  <= cfg_wdata[COORD_W-1:0];
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[COORD_W-1:0];
        REG_COLOR:  cfg_r.color  <= cfg_wdata[COLOR_W-1:0];
        REG_STRIDE: cfg_r.stride <= cfg_wdata[STRIDE_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  btr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  btr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  btr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (GLYPH_STORE_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btr_back #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/core/btr_ram.sv -----
// ----------------------------------------------------------------------------
// btr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module btr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/btr_front.sv -----
// ----------------------------------------------------------------------------
// btr_front
// Accepts items, tracks the text cursor and turns each item into a command.
// ----------------------------------------------------------------------------
module btr_front import btr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  btr_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] adv_x;
  logic               wrap;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.kind      = (in_ch.func == FUNC_DRAW) ? CMD_DRAW : CMD_LOAD;
    q_cmd.font_byte = in_ch.font_byte;
    q_cmd.x         = cur_x_r;
    q_cmd.y         = cur_y_r;
    if (in_ch.func == FUNC_DRAW) begin
      q_cmd.index = CMD_IDX_W'(in_ch.char_code) * CMD_IDX_W'(cfg.stride);
    end else begin
      q_cmd.index = CMD_IDX_W'(in_ch.font_address);
    end
  end

  // Advance by one character; wrap when the next one would not fit
  assign adv_x = cur_x_r + COORD_W'(CHAR_ADVANCE);
  assign wrap  = ({1'b0, adv_x} + (COORD_W+1)'(CHAR_ADVANCE)) > {1'b0, cfg.width};

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (q_push && in_ch.func == FUNC_DRAW) begin
      if (wrap) begin
        cur_x_nxt = '0;
        cur_y_nxt = cur_y_r + COORD_W'(LINE_ADVANCE);
      end else begin
        cur_x_nxt = adv_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= COORD_W'(CURSOR_X_RESET);
      cur_y_r <= COORD_W'(CURSOR_Y_RESET);
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule

// ----- rtl/core/btr_queue.sv -----
// ----------------------------------------------------------------------------
// btr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module btr_queue import btr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/btr_back.sv -----
// ----------------------------------------------------------------------------
// btr_back
// Executes queued commands: glyph store writes and sixteen-row glyph draws.
// ----------------------------------------------------------------------------
module btr_back import btr_pkg::*; #(
  parameter int unsigned GLYPH_STORE_DEPTH = GLYPH_STORE_DEPTH_DEF,
  localparam int unsigned AW               = $clog2(GLYPH_STORE_DEPTH)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic        ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  btr_out_if.source   out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROWS
  } state_t;

  localparam logic [CMD_IDX_W:0] DEPTH_W = (CMD_IDX_W+1)'(GLYPH_STORE_DEPTH);

  state_t                state_r, state_nxt;
  cmd_kind_t             kind_r, kind_nxt;
  logic [CMD_IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic [COORD_W-1:0]    x_r, x_nxt;
  logic [ADDR_W-1:0]     prod_r, prod_nxt;
  logic [ADDR_W-1:0]     row_addr_r, row_addr_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0]     s1_addr_r, s1_addr_nxt;
  logic                  s1_last_r, s1_last_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [BYTE_W-1:0]     out_mask_r, out_mask_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  s1_adv;
  logic                  issue;
  logic                  idx_big;
  logic [CMD_IDX_W:0]    idx_inc;
  logic                  row_last;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign issue    = (state_r == ST_ROWS) && (!s1_valid_r || s1_adv);
  assign idx_big  = ({1'b0, idx_r} >= DEPTH_W);
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign row_last = (row_r == ROW_W'(GLYPH_ROWS - 1));
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  assign ram_waddr = idx_r[AW-1:0];
  assign ram_wdata = byte_r;
  assign ram_raddr = idx_r[AW-1:0];
  assign ram_re    = issue;
  assign ram_we    = (state_r == ST_REDUCE) && !idx_big && (kind_r == CMD_LOAD);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    byte_nxt     = byte_r;
    x_nxt        = x_r;
    prod_nxt     = prod_r;
    row_addr_nxt = row_addr_r;
    row_nxt      = row_r;
    s1_valid_nxt = s1_valid_r;
    s1_addr_nxt  = s1_addr_r;
    s1_last_nxt  = s1_last_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          kind_nxt  = q_head.kind;
          idx_nxt   = q_head.index;
          byte_nxt  = q_head.font_byte;
          x_nxt     = q_head.x;
          prod_nxt  = ADDR_W'(q_head.y) * ADDR_W'(cfg.pitch);
          row_nxt   = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // Bring the store index below the depth, one subtraction a cycle
        row_addr_nxt = cfg.base + ADDR_W'(x_r) + prod_r;
        if (idx_big) begin
          idx_nxt = idx_r - DEPTH_W[CMD_IDX_W-1:0];
        end else if (kind_r == CMD_LOAD) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (issue) begin
          idx_nxt      = (idx_inc == DEPTH_W) ? '0 : idx_inc[CMD_IDX_W-1:0];
          row_addr_nxt = row_addr_r + ADDR_W'(cfg.pitch);
          row_nxt      = row_r + 1'b1;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Read stage: address and row flag travel alongside the store read
    if (issue) begin
      s1_valid_nxt = 1'b1;
      s1_addr_nxt  = row_addr_r;
      s1_last_nxt  = row_last;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    // Output register
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = s1_addr_r;
      out_mask_nxt  = ram_rdata;
      out_last_nxt  = s1_last_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    byte_r     <= byte_nxt;
    x_r        <= x_nxt;
    prod_r     <= prod_nxt;
    row_addr_r <= row_addr_nxt;
    row_r      <= row_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_last_r  <= s1_last_nxt;
    out_addr_r <= out_addr_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.row_mask      = out_mask_r;
  assign out_ch.pixel_color   = cfg.color;
  assign out_ch.last_row      = out_last_r;

endmodule
